[rtl/isfp_pkg.sv]
// Package for the inverter status frame parser.
// Holds the transaction payload types, frame layout constants and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isfp_pkg;

  localparam int FRAME_BYTES  = 27;
  localparam int SUMMED_BYTES = 14;
  localparam int STORED_BYTES = FRAME_BYTES - 1;
  localparam int POS_W        = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SUM_LIMIT  = POS_W'(SUMMED_BYTES);

  localparam int CKSUM_AT  = 14;
  localparam int ID_AT     = 6;
  localparam int ENERGY_AT = 10;
  localparam int DCV_AT    = 15;
  localparam int DCI_AT    = 17;
  localparam int ACV_AT    = 19;
  localparam int ACI_AT    = 21;
  localparam int STATE_AT  = 25;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

  localparam logic CFG_HEADER_MAGIC  = 1'b0;
  localparam logic CFG_STATUS_OPCODE = 1'b1;

  typedef logic [STORED_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] device_id;
    logic [31:0] total_energy;
    logic [15:0] dc_voltage_raw;
    logic [15:0] dc_current_raw;
    logic [15:0] ac_voltage_raw;
    logic [15:0] ac_current_raw;
    logic [31:0] dc_power_raw;
    logic [31:0] ac_power_raw;
    logic [7:0]  device_state;
    logic [7:0]  device_temperature;
  } out_t;

endpackage

`default_nettype wire

[rtl/isfp_decode.sv]
// Frame decoder: header and checksum checks, big-endian field assembly, power products.
// Depends on isfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isfp_decode (
  input  wire isfp_pkg::frame_t frame,
  input  wire logic [7:0]       last_byte,
  input  wire logic [7:0]       sum,
  input  wire logic [7:0]       header_magic,
  input  wire logic [7:0]       status_opcode,
  output isfp_pkg::out_t        result
);

  logic [15:0] dcv;
  logic [15:0] dci;
  logic [15:0] acv;
  logic [15:0] aci;

  always_comb begin
    dcv = {frame[isfp_pkg::DCV_AT], frame[isfp_pkg::DCV_AT+1]};
    dci = {frame[isfp_pkg::DCI_AT], frame[isfp_pkg::DCI_AT+1]};
    acv = {frame[isfp_pkg::ACV_AT], frame[isfp_pkg::ACV_AT+1]};
    aci = {frame[isfp_pkg::ACI_AT], frame[isfp_pkg::ACI_AT+1]};

    priority if (frame[0] != header_magic || frame[1] != status_opcode) begin
      result.frame_status = isfp_pkg::STATUS_BAD_HDR;
    end else if (frame[isfp_pkg::CKSUM_AT] != sum) begin
      result.frame_status = isfp_pkg::STATUS_BAD_SUM;
    end else begin
      result.frame_status = isfp_pkg::STATUS_OK;
    end

    result.device_id    = {frame[isfp_pkg::ID_AT], frame[isfp_pkg::ID_AT+1],
                           frame[isfp_pkg::ID_AT+2], frame[isfp_pkg::ID_AT+3]};
    result.total_energy = {frame[isfp_pkg::ENERGY_AT], frame[isfp_pkg::ENERGY_AT+1],
                           frame[isfp_pkg::ENERGY_AT+2], frame[isfp_pkg::ENERGY_AT+3]};
    result.dc_voltage_raw     = dcv;
    result.dc_current_raw     = dci;
    result.ac_voltage_raw     = acv;
    result.ac_current_raw     = aci;
    result.dc_power_raw       = {16'd0, dcv} * {16'd0, dci};
    result.ac_power_raw       = {16'd0, acv} * {16'd0, aci};
    result.device_state       = frame[isfp_pkg::STATE_AT];
    result.device_temperature = last_byte;
  end

endmodule

`default_nettype wire

[rtl/inverter_status_frame_parser.sv]
// Top level of the inverter status frame parser: byte framing, running checksum, result register.
// Depends on isfp_pkg and isfp_decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per cycle while in_ready is high and groups the stream
// into 27-byte status frames; restart forces the byte to be byte 0 of a new
// frame and drops any partial frame. On byte 26 one result transaction is loaded
// into the output register, holding the status (header check before checksum
// check) and the decoded fields with both power products. The two 16 x 16
// multipliers feeding the output register set the critical path.
// Input ready only drops for a frame's last byte while a previous result is
// still held and not being taken; other bytes are accepted regardless.
// Header values are written over the cfg port (index 0 magic, 1 opcode).
module inverter_status_frame_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire isfp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output isfp_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data
);

  logic [7:0]                   header_magic;
  logic [7:0]                   status_opcode;
  logic [isfp_pkg::POS_W-1:0]   byte_position;
  logic [isfp_pkg::POS_W-1:0]   byte_position_next;
  logic [7:0]                   running_sum;
  logic [7:0]                   running_sum_next;
  isfp_pkg::frame_t             frame_store;

  logic [isfp_pkg::POS_W-1:0]   pos;
  logic [7:0]                   sum_base;
  logic                         is_last;
  logic                         accept;
  isfp_pkg::out_t               decoded;

  always_comb begin
    pos      = in_data.restart ? '0 : byte_position;
    sum_base = in_data.restart ? 8'd0 : running_sum;
    is_last  = (pos == isfp_pkg::LAST_POS);
    in_ready = !(is_last && out_valid && !out_ready);
    accept   = in_valid && in_ready;

    if (is_last) begin
      byte_position_next = '0;
      running_sum_next   = 8'd0;
    end else begin
      byte_position_next = pos + 1'b1;
      running_sum_next   = (pos < isfp_pkg::SUM_LIMIT) ? sum_base + in_data.rx_byte
                                                       : sum_base;
    end
  end

  isfp_decode u_decode (
    .frame         (frame_store),
    .last_byte     (in_data.rx_byte),
    .sum           (running_sum),
    .header_magic  (header_magic),
    .status_opcode (status_opcode),
    .result        (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_magic  <= 8'd0;
      status_opcode <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isfp_pkg::CFG_HEADER_MAGIC:  header_magic  <= cfg_data;
        isfp_pkg::CFG_STATUS_OPCODE: status_opcode <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= byte_position_next;
        running_sum   <= running_sum_next;
      end
      if (accept && is_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (accept && !is_last) begin
      frame_store[pos] <= in_data.rx_byte;
    end
    if (accept && is_last) begin
      out_data <= decoded;
    end
  end

endmodule

`default_nettype wire
